FILE: hdl/rrfb_pkg.sv
package rrfb_pkg;

  // default screen geometry
  localparam int SCREEN_WIDTH_DEF  = 640;
  localparam int SCREEN_HEIGHT_DEF = 480;

  // field widths
  localparam int CMD_W    = 3;
  localparam int COORD_W  = 16;
  localparam int SRC_W    = 15;
  localparam int COLOUR_W = 16;
  localparam int COUNT_W  = 19;
  localparam int SEG_W    = 18;

  // stream widths
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_PAD_W  = OUT_DATA_W - COLOUR_W - COUNT_W - 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef logic [CMD_W-1:0] cmd_t;

  // command codes
  localparam cmd_t CMD_CLEAR   = 3'd0;
  localparam cmd_t CMD_FILL    = 3'd1;
  localparam cmd_t CMD_OUTLINE = 3'd2;
  localparam cmd_t CMD_BLIT    = 3'd3;
  localparam cmd_t CMD_COUNT   = 3'd4;
  localparam cmd_t CMD_READ    = 3'd5;

  // controller to datapath
  typedef struct packed {
    logic       accept;
    logic       seg_load;
    logic [1:0] seg_sel;
    logic       clip_load;
    logic       walk_load;
    logic       walk_step;
    logic       result_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic empty;
    logic last;
    logic out_busy;
  } stat_t;

  function automatic logic is_read_cmd(cmd_t c);
    return (c == CMD_COUNT) || (c == CMD_READ);
  endfunction

endpackage

FILE: hdl/rrfb_ram.sv
module rrfb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/rrfb_ctrl.sv
module rrfb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  rrfb_pkg::stat_t stat,
  output rrfb_pkg::ctrl_t ctrl
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEG   = 3'd1;
  localparam logic [2:0] S_CLIP  = 3'd2;
  localparam logic [2:0] S_ADDR  = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] seg_idx;
  logic [1:0] seg_idx_next;
  logic       more_segs;

  // outline runs four segments, everything else one
  assign more_segs = (stat.cmd == rrfb_pkg::CMD_OUTLINE) && (seg_idx != 2'd3);
  assign in_ready  = (state == S_IDLE);

  // next state and datapath commands
  always_comb begin
    state_next   = state;
    seg_idx_next = seg_idx;
    ctrl         = '0;
    ctrl.seg_sel = seg_idx;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept  = 1'b1;
          seg_idx_next = 2'd0;
          state_next   = S_SEG;
        end
      end
      S_SEG: begin
        if (stat.cmd inside {rrfb_pkg::CMD_CLEAR, rrfb_pkg::CMD_FILL, rrfb_pkg::CMD_OUTLINE,
                             rrfb_pkg::CMD_BLIT, rrfb_pkg::CMD_COUNT, rrfb_pkg::CMD_READ}) begin
          ctrl.seg_load = 1'b1;
          state_next    = S_CLIP;
        end else begin
          state_next = S_DONE;
        end
      end
      S_CLIP: begin
        ctrl.clip_load = 1'b1;
        state_next     = S_ADDR;
      end
      S_ADDR: begin
        ctrl.walk_load = 1'b1;
        if (!stat.empty) begin
          state_next = S_WALK;
        end else if (more_segs) begin
          seg_idx_next = seg_idx + 2'd1;
          state_next   = S_SEG;
        end else begin
          state_next = S_DONE;
        end
      end
      S_WALK: begin
        ctrl.walk_step = 1'b1;
        if (stat.last) begin
          if (rrfb_pkg::is_read_cmd(stat.cmd)) begin
            state_next = S_DRAIN;
          end else if (more_segs) begin
            seg_idx_next = seg_idx + 2'd1;
            state_next   = S_SEG;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          ctrl.result_load = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      seg_idx <= 2'd0;
    end else begin
      state   <= state_next;
      seg_idx <= seg_idx_next;
    end
  end

endmodule

FILE: hdl/rrfb_datapath.sv
module rrfb_datapath #(
  parameter int SCREEN_WIDTH  = rrfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rrfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rrfb_pkg::ctrl_t                     ctrl,
  input  logic [rrfb_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [rrfb_pkg::CMD_W-1:0]          in_user,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rrfb_pkg::OUT_DATA_W-1:0]     out_data,
  output rrfb_pkg::stat_t                     stat
);

  localparam int PIX_TOTAL = SCREEN_WIDTH * SCREEN_HEIGHT;
  localparam int XW = (SCREEN_WIDTH > 1) ? $clog2(SCREEN_WIDTH) : 1;
  localparam int YW = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;
  localparam int AW = (PIX_TOTAL > 1) ? $clog2(PIX_TOTAL) : 1;
  localparam int SW = rrfb_pkg::SEG_W;
  localparam logic signed [SW-1:0] SCR_W_S = SW'(SCREEN_WIDTH);
  localparam logic signed [SW-1:0] SCR_H_S = SW'(SCREEN_HEIGHT);
  localparam logic signed [SW-1:0] ONE_S   = SW'(1);
  localparam logic [AW-1:0]        SCR_W_A = AW'(SCREEN_WIDTH);

  // command fields
  rrfb_pkg::cmd_t                         cmd_q;
  logic signed [rrfb_pkg::COORD_W-1:0]    pos_x;
  logic signed [rrfb_pkg::COORD_W-1:0]    pos_y;
  logic signed [rrfb_pkg::COORD_W-1:0]    rect_width;
  logic signed [rrfb_pkg::COORD_W-1:0]    rect_height;
  logic [rrfb_pkg::SRC_W-1:0]             src_col;
  logic [rrfb_pkg::SRC_W-1:0]             src_row;
  logic [rrfb_pkg::COLOUR_W-1:0]          colour;

  // segment and clip
  logic signed [SW-1:0] seg_x_next, seg_y_next, seg_w_next, seg_h_next;
  logic signed [SW-1:0] seg_x, seg_y, seg_w, seg_h;
  logic signed [SW-1:0] x0s, y0s, x1s, y1s, x1m1s, y1m1s;
  logic signed [SW-1:0] xs, ys, ws, hs;
  logic                 rect_ok, blit_ok;
  logic [XW-1:0]        x0, x1m1, ix;
  logic [YW-1:0]        y0, y1m1, iy;
  logic                 empty;

  // walker
  logic [AW-1:0] start_addr;
  logic [AW-1:0] addr;
  logic [AW-1:0] row_base;
  logic          rd_mode;
  logic          rd_pend;
  logic [rrfb_pkg::COLOUR_W-1:0] rdata;

  // results
  logic [rrfb_pkg::COUNT_W-1:0]  count;
  logic [rrfb_pkg::COLOUR_W-1:0] pixel;

  // capture command beat
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      cmd_q       <= in_user;
      pos_x       <= in_data[15:0];
      pos_y       <= in_data[31:16];
      rect_width  <= in_data[47:32];
      rect_height <= in_data[63:48];
      src_col     <= in_data[78:64];
      src_row     <= in_data[93:79];
      colour      <= in_data[109:94];
    end
  end

  assign xs      = SW'(pos_x);
  assign ys      = SW'(pos_y);
  assign ws      = SW'(rect_width);
  assign hs      = SW'(rect_height);
  assign rect_ok = (rect_width > 0) && (rect_height > 0);
  assign blit_ok = rect_ok && ($signed({3'b000, src_col}) < SW'(rect_width))
                   && ($signed({3'b000, src_row}) < SW'(rect_height));
  assign rd_mode = rrfb_pkg::is_read_cmd(cmd_q);

  // segment selection per command
  always_comb begin
    seg_x_next = '0;
    seg_y_next = '0;
    seg_w_next = '0;
    seg_h_next = '0;
    case (cmd_q)
      rrfb_pkg::CMD_CLEAR, rrfb_pkg::CMD_COUNT: begin
        seg_w_next = SCR_W_S;
        seg_h_next = SCR_H_S;
      end
      rrfb_pkg::CMD_FILL: begin
        seg_x_next = xs;
        seg_y_next = ys;
        seg_w_next = ws;
        seg_h_next = hs;
      end
      rrfb_pkg::CMD_OUTLINE: begin
        if (rect_ok) begin
          seg_x_next = xs;
          seg_y_next = ys;
          case (ctrl.seg_sel)
            2'd0: begin
              seg_w_next = ws;
              seg_h_next = ONE_S;
            end
            2'd1: begin
              seg_y_next = ys + hs - ONE_S;
              seg_w_next = ws;
              seg_h_next = ONE_S;
            end
            2'd2: begin
              seg_w_next = ONE_S;
              seg_h_next = hs;
            end
            2'd3: begin
              seg_x_next = xs + ws - ONE_S;
              seg_w_next = ONE_S;
              seg_h_next = hs;
            end
            default: begin
              seg_w_next = '0;
            end
          endcase
        end
      end
      rrfb_pkg::CMD_BLIT: begin
        if (blit_ok) begin
          seg_x_next = xs + SW'(src_col);
          seg_y_next = ys + SW'(src_row);
          seg_w_next = ONE_S;
          seg_h_next = ONE_S;
        end
      end
      rrfb_pkg::CMD_READ: begin
        seg_x_next = xs;
        seg_y_next = ys;
        seg_w_next = ONE_S;
        seg_h_next = ONE_S;
      end
      default: begin
        seg_w_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.seg_load) begin
      seg_x <= seg_x_next;
      seg_y <= seg_y_next;
      seg_w <= seg_w_next;
      seg_h <= seg_h_next;
    end
  end

  // clip segment to the screen
  always_comb begin
    x0s = (seg_x < 0) ? '0 : seg_x;
    y0s = (seg_y < 0) ? '0 : seg_y;
    x1s = seg_x + seg_w;
    y1s = seg_y + seg_h;
    if (x1s > SCR_W_S) begin
      x1s = SCR_W_S;
    end
    if (y1s > SCR_H_S) begin
      y1s = SCR_H_S;
    end
    x1m1s = x1s - ONE_S;
    y1m1s = y1s - ONE_S;
  end

  always_ff @(posedge clk) begin
    if (ctrl.clip_load) begin
      x0    <= x0s[XW-1:0];
      y0    <= y0s[YW-1:0];
      x1m1  <= x1m1s[XW-1:0];
      y1m1  <= y1m1s[YW-1:0];
      empty <= (x0s >= x1s) || (y0s >= y1s);
    end
  end

  // raster walk, one pixel a cycle
  assign start_addr = AW'(y0) * SCR_W_A + AW'(x0);

  always_ff @(posedge clk) begin
    if (ctrl.walk_load) begin
      ix       <= x0;
      iy       <= y0;
      addr     <= start_addr;
      row_base <= start_addr;
    end else if (ctrl.walk_step) begin
      if (ix == x1m1) begin
        ix       <= x0;
        iy       <= iy + YW'(1);
        row_base <= row_base + SCR_W_A;
        addr     <= row_base + SCR_W_A;
      end else begin
        ix   <= ix + XW'(1);
        addr <= addr + AW'(1);
      end
    end
  end

  rrfb_ram #(
    .WIDTH (rrfb_pkg::COLOUR_W),
    .DEPTH (PIX_TOTAL)
  ) u_frame_store (
    .clk   (clk),
    .we    (ctrl.walk_step && !rd_mode),
    .waddr (addr),
    .wdata (colour),
    .raddr (addr),
    .rdata (rdata)
  );

  // read data is registered and arrives in the cycle after the address
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= ctrl.walk_step && rd_mode;
    end
  end

  // count and read back
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      count <= '0;
      pixel <= '0;
    end else if (rd_pend) begin
      if (cmd_q == rrfb_pkg::CMD_COUNT) begin
        if ((rdata == colour) && (count != rrfb_pkg::COUNT_MAX)) begin
          count <= count + rrfb_pkg::COUNT_W'(1);
        end
      end else begin
        pixel <= rdata;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.result_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.result_load) begin
      out_data <= {{rrfb_pkg::OUT_PAD_W{1'b0}}, 1'b1, count, pixel};
    end
  end

  assign stat.cmd      = cmd_q;
  assign stat.empty    = empty;
  assign stat.last     = (ix == x1m1) && (iy == y1m1);
  assign stat.out_busy = out_valid && !out_ready;

endmodule

FILE: hdl/rgb565_rect_fill_blit_engine.sv
// per segment: seg, clip, addr states, then one pixel a cycle; done registers the result
// fill and blit are one segment, outline four; clear and count walk all width*height pixels
// count and read pass through a drain state for the registered frame store read
// throughput: one command at a time, set by the one-pixel-a-cycle frame store walk
// reset clears the controller and output valid; frame store contents stay undefined
module rgb565_rect_fill_blit_engine #(
  parameter int SCREEN_WIDTH  = rrfb_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = rrfb_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pos_x, pos_y, rect_width, rect_height, src_col, src_row, colour
  input  logic [rrfb_pkg::IN_DATA_W-1:0]     s_axis_tdata,
  // command
  input  logic [rrfb_pkg::CMD_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_value, colour_count, done_res
  output logic [rrfb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  rrfb_pkg::ctrl_t ctrl;
  rrfb_pkg::stat_t stat;

  // sequencer
  rrfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  // clip, walk, frame store and result
  rrfb_datapath #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .stat      (stat)
  );

endmodule
